[sv/pdl_pkg.sv]
// -----------------------------------------------------------------------------
// pdl_pkg
// Types and constants shared by the password door lock controller files.
// -----------------------------------------------------------------------------
`default_nettype none

package pdl_pkg;

   // Controller phases, one-hot
   typedef enum logic [10:0] {
      PH_CREATE_START1 = 11'b000_0000_0001,
      PH_CREATE_PW1    = 11'b000_0000_0010,
      PH_CREATE_START2 = 11'b000_0000_0100,
      PH_CREATE_PW2    = 11'b000_0000_1000,
      PH_IDLE          = 11'b000_0001_0000,
      PH_OP_START      = 11'b000_0010_0000,
      PH_OP_PW         = 11'b000_0100_0000,
      PH_OPENING       = 11'b000_1000_0000,
      PH_MOTION        = 11'b001_0000_0000,
      PH_LOCKING       = 11'b010_0000_0000,
      PH_ALARM         = 11'b100_0000_0000
   } phase_type;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_OPEN_CODE     = 3'd0;
   localparam logic [2:0] REG_CHANGE_CODE   = 3'd1;
   localparam logic [2:0] REG_RETRY_CODE    = 3'd2;
   localparam logic [2:0] REG_START_CODE    = 3'd3;
   localparam logic [2:0] REG_WAIT_CODE     = 3'd4;
   localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd5;
   localparam logic [2:0] REG_MOTOR_TICKS   = 3'd6;
   localparam logic [2:0] REG_ALARM_TICKS   = 3'd7;

   // Register reset values
   localparam logic [7:0] OPEN_CODE_RST     = 8'd2;
   localparam logic [7:0] CHANGE_CODE_RST   = 8'd3;
   localparam logic [7:0] RETRY_CODE_RST    = 8'd4;
   localparam logic [7:0] START_CODE_RST    = 8'd165;
   localparam logic [7:0] WAIT_CODE_RST     = 8'd85;
   localparam logic [3:0] ATTEMPT_LIMIT_RST = 4'd3;
   localparam logic [5:0] MOTOR_TICKS_RST   = 6'd15;
   localparam logic [5:0] ALARM_TICKS_RST   = 6'd60;

   // Item kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Motor commands
   localparam logic [1:0] MOTOR_STOP    = 2'd0;
   localparam logic [1:0] MOTOR_FORWARD = 2'd1;
   localparam logic [1:0] MOTOR_REVERSE = 2'd2;

   // Reply bytes
   localparam logic [7:0] TX_PASS = 8'd1;
   localparam logic [7:0] TX_FAIL = 8'd0;

   // Attempt counter saturation
   localparam logic [3:0] ATTEMPT_MAX = 4'd15;

endpackage

`default_nettype wire

[sv/pdl_if.sv]
// -----------------------------------------------------------------------------
// pdl_if
// Valid/ready channels of the door lock controller: request items and results.
// -----------------------------------------------------------------------------
`default_nettype none

interface pdl_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;
   logic       motion;

   modport source (output valid, output command, output rx_byte, output motion,
                   input ready);
   modport sink   (input valid, input command, input rx_byte, input motion,
                   output ready);
endinterface

interface pdl_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic [1:0] motor_drive;
   logic       buzzer_active;
   logic       busy_res;

   modport source (output valid, output tx_valid, output tx_byte, output motor_drive,
                   output buzzer_active, output busy_res, input ready);
   modport sink   (input valid, input tx_valid, input tx_byte, input motor_drive,
                   input buzzer_active, input busy_res, output ready);
endinterface

`default_nettype wire

[sv/password_door_lock_controller.sv]
// A result is presented in the cycle after its item is accepted.
// Throughput: one item per cycle; the state update and result are computed in
// one pass from the accepted item and the controller state into the result
// register, and a new item is taken whenever that register is empty or drains.
// Reset (synchronous): back to waiting for the first start code, stored
// password zero, registers at their default values, result register empty.
// -----------------------------------------------------------------------------
// password_door_lock_controller
// Keypad door lock controller: password creation and checking, motor open and
// lock sequencing with motion hold-off, and an alarm after repeated failures.
// -----------------------------------------------------------------------------
`default_nettype none

module password_door_lock_controller #(
   parameter int PW_LEN = 5
) (
   input  wire         clock,
   input  wire         reset,
   pdl_req_if.sink     req_chan,
   pdl_rsp_if.source   rsp_chan,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pdl_pkg::*;

   localparam int IDX_W = (PW_LEN > 1) ? $clog2(PW_LEN) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PW_LEN - 1);

   // Configuration registers
   logic [7:0] open_code_ff, change_code_ff, retry_code_ff, start_code_ff, wait_code_ff;
   logic [3:0] attempt_limit_ff;
   logic [5:0] motor_ticks_ff, alarm_ticks_ff;

   // Controller state
   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             mismatch_ff, mismatch_in;
   logic [3:0]       attempt_ff, attempt_in;
   logic [5:0]       tick_ff, tick_in;
   logic             pending_ff, pending_in;
   logic [7:0]       first_pw_ff [PW_LEN];
   logic [7:0]       stored_pw_ff [PW_LEN];

   // Result register
   logic       rsp_valid_ff;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic [1:0] motor_ff, motor_in;
   logic       buzzer_ff, buzzer_in;
   logic       busy_ff, busy_in;

   logic       accept;
   logic       csr_write;
   logic       first_wr;
   logic       store_copy;
   logic [5:0] tick_inc;
   logic       motor_done, alarm_done;
   logic       last_byte;
   logic       first_miss, stored_miss;
   logic [3:0] attempt_inc;

   assign accept    = req_chan.valid && req_chan.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign req_chan.ready         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.tx_valid      = tx_valid_ff;
   assign rsp_chan.tx_byte       = tx_byte_ff;
   assign rsp_chan.motor_drive   = motor_ff;
   assign rsp_chan.buzzer_active = buzzer_ff;
   assign rsp_chan.busy_res      = busy_ff;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         open_code_ff     <= OPEN_CODE_RST;
         change_code_ff   <= CHANGE_CODE_RST;
         retry_code_ff    <= RETRY_CODE_RST;
         start_code_ff    <= START_CODE_RST;
         wait_code_ff     <= WAIT_CODE_RST;
         attempt_limit_ff <= ATTEMPT_LIMIT_RST;
         motor_ticks_ff   <= MOTOR_TICKS_RST;
         alarm_ticks_ff   <= ALARM_TICKS_RST;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_OPEN_CODE:     open_code_ff     <= csr_pwdata[7:0];
            REG_CHANGE_CODE:   change_code_ff   <= csr_pwdata[7:0];
            REG_RETRY_CODE:    retry_code_ff    <= csr_pwdata[7:0];
            REG_START_CODE:    start_code_ff    <= csr_pwdata[7:0];
            REG_WAIT_CODE:     wait_code_ff     <= csr_pwdata[7:0];
            REG_ATTEMPT_LIMIT: attempt_limit_ff <= csr_pwdata[3:0];
            REG_MOTOR_TICKS:   motor_ticks_ff   <= csr_pwdata[5:0];
            REG_ALARM_TICKS:   alarm_ticks_ff   <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_OPEN_CODE:     csr_prdata = {24'd0, open_code_ff};
         REG_CHANGE_CODE:   csr_prdata = {24'd0, change_code_ff};
         REG_RETRY_CODE:    csr_prdata = {24'd0, retry_code_ff};
         REG_START_CODE:    csr_prdata = {24'd0, start_code_ff};
         REG_WAIT_CODE:     csr_prdata = {24'd0, wait_code_ff};
         REG_ATTEMPT_LIMIT: csr_prdata = {28'd0, attempt_limit_ff};
         REG_MOTOR_TICKS:   csr_prdata = {26'd0, motor_ticks_ff};
         REG_ALARM_TICKS:   csr_prdata = {26'd0, alarm_ticks_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Shared terms
   assign tick_inc    = tick_ff + 6'd1;
   assign motor_done  = (tick_inc >= motor_ticks_ff) || (tick_inc == 6'd0);
   assign alarm_done  = (tick_inc >= alarm_ticks_ff) || (tick_inc == 6'd0);
   assign last_byte   = (idx_ff == IDX_LAST);
   assign first_miss  = mismatch_ff || (first_pw_ff[idx_ff] != req_chan.rx_byte);
   assign stored_miss = mismatch_ff || (stored_pw_ff[idx_ff] != req_chan.rx_byte);
   assign attempt_inc = (attempt_ff < ATTEMPT_MAX) ? attempt_ff + 4'd1 : attempt_ff;

   // Next state and result
   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      mismatch_in = mismatch_ff;
      attempt_in  = attempt_ff;
      tick_in     = tick_ff;
      pending_in  = pending_ff;
      first_wr    = 1'b0;
      store_copy  = 1'b0;
      tx_valid_in = 1'b0;
      tx_byte_in  = TX_FAIL;

      if (phase_ff == PH_MOTION || (req_chan.command == CMD_TICK &&
                                    phase_ff == PH_OPENING && motor_done)) begin
         // sample motion: hold the door open or start locking
         tx_valid_in = 1'b1;
         if (req_chan.motion) begin
            tx_byte_in = wait_code_ff;
            phase_in   = PH_MOTION;
         end else begin
            tx_byte_in = TX_FAIL;
            phase_in   = PH_LOCKING;
         end
         tick_in = 6'd0;
      end else if (req_chan.command == CMD_TICK) begin
         unique case (phase_ff)
            PH_OPENING: tick_in = tick_inc;
            PH_LOCKING: begin
               tick_in = motor_done ? 6'd0 : tick_inc;
               if (motor_done) phase_in = PH_IDLE;
            end
            PH_ALARM: begin
               tick_in = alarm_done ? 6'd0 : tick_inc;
               if (alarm_done) begin
                  attempt_in = 4'd0;
                  phase_in   = PH_IDLE;
               end
            end
            default: ;
         endcase
      end else begin
         unique case (phase_ff)
            PH_CREATE_START1: begin
               if (req_chan.rx_byte == start_code_ff) begin
                  phase_in = PH_CREATE_PW1;
                  idx_in   = '0;
               end
            end
            PH_CREATE_PW1: begin
               first_wr = 1'b1;
               if (last_byte) begin
                  idx_in   = '0;
                  phase_in = PH_CREATE_START2;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            PH_CREATE_START2: begin
               if (req_chan.rx_byte == start_code_ff) begin
                  phase_in    = PH_CREATE_PW2;
                  idx_in      = '0;
                  mismatch_in = 1'b0;
               end
            end
            PH_CREATE_PW2: begin
               mismatch_in = first_miss;
               if (last_byte) begin
                  store_copy  = !first_miss;
                  tx_valid_in = 1'b1;
                  tx_byte_in  = first_miss ? TX_FAIL : TX_PASS;
                  idx_in      = '0;
                  phase_in    = PH_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            PH_IDLE: begin
               if (req_chan.rx_byte == open_code_ff || req_chan.rx_byte == change_code_ff) begin
                  pending_in = (req_chan.rx_byte == open_code_ff);
                  phase_in   = PH_OP_START;
               end else if (req_chan.rx_byte == retry_code_ff) begin
                  phase_in = PH_CREATE_START1;
               end
            end
            PH_OP_START: begin
               if (req_chan.rx_byte == start_code_ff) begin
                  phase_in    = PH_OP_PW;
                  idx_in      = '0;
                  mismatch_in = 1'b0;
               end
            end
            PH_OP_PW: begin
               mismatch_in = stored_miss;
               if (last_byte) begin
                  idx_in      = '0;
                  tx_valid_in = 1'b1;
                  pending_in  = 1'b0;
                  if (!stored_miss) begin
                     tx_byte_in = TX_PASS;
                     attempt_in = 4'd0;
                     if (pending_ff) begin
                        phase_in = PH_OPENING;
                        tick_in  = 6'd0;
                     end else begin
                        phase_in = PH_CREATE_START1;
                     end
                  end else begin
                     tx_byte_in = TX_FAIL;
                     attempt_in = attempt_inc;
                     if (attempt_inc >= attempt_limit_ff) begin
                        phase_in = PH_ALARM;
                        tick_in  = 6'd0;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end

      // outputs reflect the phase after this item
      motor_in  = (phase_in == PH_OPENING) ? MOTOR_FORWARD :
                  (phase_in == PH_LOCKING) ? MOTOR_REVERSE : MOTOR_STOP;
      buzzer_in = (phase_in == PH_ALARM);
      busy_in   = (phase_in == PH_OPENING) || (phase_in == PH_MOTION) ||
                  (phase_in == PH_LOCKING) || (phase_in == PH_ALARM);
   end

   // Controller state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CREATE_START1;
         idx_ff      <= '0;
         mismatch_ff <= 1'b0;
         attempt_ff  <= 4'd0;
         tick_ff     <= 6'd0;
         pending_ff  <= 1'b0;
         for (int i = 0; i < PW_LEN; i++) begin
            stored_pw_ff[i] <= 8'd0;
         end
      end else if (accept) begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         mismatch_ff <= mismatch_in;
         attempt_ff  <= attempt_in;
         tick_ff     <= tick_in;
         pending_ff  <= pending_in;
         if (store_copy) begin
            for (int i = 0; i < PW_LEN; i++) begin
               stored_pw_ff[i] <= first_pw_ff[i];
            end
         end
      end
   end

   // First password entry store, written before it is read
   always_ff @(posedge clock) begin
      if (accept && first_wr) begin
         first_pw_ff[idx_ff] <= req_chan.rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tx_valid_ff <= tx_valid_in;
         tx_byte_ff  <= tx_valid_in ? tx_byte_in : TX_FAIL;
         motor_ff    <= motor_in;
         buzzer_ff   <= buzzer_in;
         busy_ff     <= busy_in;
      end
   end

endmodule

`default_nettype wire

[tb/password_door_lock_controller_tb.sv]
// -----------------------------------------------------------------------------
// password_door_lock_controller_tb
// Self-checking bench for the door lock controller. A queue of pending items
// feeds a valid/ready driver and a shadow model of the lock predicts one reply
// per accepted item. The monitor checks each result against the oldest
// prediction. A state-aware generator steers the items through password
// creation, open and change requests, motor runs, motion hold-off and alarms.
// It runs under several register settings and several idle and stall mixes.
// -----------------------------------------------------------------------------
module password_door_lock_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pdl_pkg::*;

   localparam int PW_LEN      = 5;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] open_code;
      logic [7:0] change_code;
      logic [7:0] retry_code;
      logic [7:0] start_code;
      logic [7:0] wait_code;
      logic [3:0] attempt_limit;
      logic [5:0] motor_ticks;
      logic [5:0] alarm_ticks;
   } lock_cfg_type;

   typedef struct packed {
      phase_type               phase;
      logic [3:0]              idx;
      logic [PW_LEN-1:0][7:0]  first_pw;
      logic [PW_LEN-1:0][7:0]  stored_pw;
      logic                    mism;
      logic [3:0]              attempts;
      logic [5:0]              ticks;
      logic                    pend_open;
   } lock_state_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
      logic       motion;
   } door_item_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [1:0] motor_drive;
      logic       buzzer_active;
      logic       busy_res;
   } door_result_type;

   typedef struct packed {
      lock_state_type  st;
      door_result_type res;
   } door_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic        drv_req_valid = 1'b0;
   logic        drv_command = CMD_BYTE;
   logic [7:0]  drv_rx_byte = '0;
   logic        drv_motion = 1'b0;
   logic        drv_rsp_ready = 1'b0;

   pdl_req_if req_bus ();
   pdl_rsp_if rsp_bus ();

   assign req_bus.valid   = drv_req_valid;
   assign req_bus.command = drv_command;
   assign req_bus.rx_byte = drv_rx_byte;
   assign req_bus.motion  = drv_motion;
   assign rsp_bus.ready   = drv_rsp_ready;

   password_door_lock_controller #(.PW_LEN(PW_LEN)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lock_cfg_type           cfg;
   lock_state_type         ctl_state;
   lock_state_type         plan_state;
   logic [PW_LEN-1:0][7:0] pw_plan;
   door_item_type          pending_items[$];
   door_result_type        expected_replies[$];
   int                     send_idle = 0;
   int                     stall_pct = 0;
   int                     fail_count = 0;
   int                     quiet = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic lock_state_type lock_reset_state();
      lock_state_type s;
      s = '0;
      s.phase = PH_CREATE_START1;
      return s;
   endfunction

   // {expired, next count}; a limit of zero expires on the first tick
   function automatic logic [6:0] tick_advance(logic [5:0] cnt, logic [5:0] lim);
      logic [5:0] nxt;
      nxt = cnt + 6'd1;
      if (nxt >= lim || nxt == 6'd0) return {1'b1, 6'd0};
      return {1'b0, nxt};
   endfunction

   function automatic door_step_type door_step(lock_cfg_type c, lock_state_type s,
                                               door_item_type it);
      door_step_type o;
      logic          sample;
      logic [6:0]    tk;
      o = '0;
      sample = 1'b0;
      if (s.phase == PH_MOTION) begin
         sample = 1'b1;
      end else if (it.command == CMD_TICK) begin
         case (s.phase)
            PH_OPENING: begin
               tk = tick_advance(s.ticks, c.motor_ticks);
               s.ticks = tk[5:0];
               sample = tk[6];
            end
            PH_LOCKING: begin
               tk = tick_advance(s.ticks, c.motor_ticks);
               s.ticks = tk[5:0];
               if (tk[6]) s.phase = PH_IDLE;
            end
            PH_ALARM: begin
               tk = tick_advance(s.ticks, c.alarm_ticks);
               s.ticks = tk[5:0];
               if (tk[6]) begin
                  s.attempts = 4'd0;
                  s.phase = PH_IDLE;
               end
            end
            default: ;
         endcase
      end else begin
         case (s.phase)
            PH_CREATE_START1: begin
               if (it.rx_byte == c.start_code) begin
                  s.phase = PH_CREATE_PW1;
                  s.idx = 4'd0;
               end
            end
            PH_CREATE_PW1: begin
               s.first_pw[s.idx] = it.rx_byte;
               s.idx = s.idx + 4'd1;
               if (s.idx >= PW_LEN) begin
                  s.idx = 4'd0;
                  s.phase = PH_CREATE_START2;
               end
            end
            PH_CREATE_START2: begin
               if (it.rx_byte == c.start_code) begin
                  s.phase = PH_CREATE_PW2;
                  s.idx = 4'd0;
                  s.mism = 1'b0;
               end
            end
            PH_CREATE_PW2: begin
               if (s.first_pw[s.idx] != it.rx_byte) s.mism = 1'b1;
               s.idx = s.idx + 4'd1;
               if (s.idx >= PW_LEN) begin
                  if (!s.mism) s.stored_pw = s.first_pw;
                  o.res.tx_valid = 1'b1;
                  o.res.tx_byte = s.mism ? TX_FAIL : TX_PASS;
                  s.idx = 4'd0;
                  s.phase = PH_IDLE;
               end
            end
            PH_IDLE: begin
               // open wins over change, change over retry
               if (it.rx_byte == c.open_code || it.rx_byte == c.change_code) begin
                  s.pend_open = (it.rx_byte == c.open_code);
                  s.phase = PH_OP_START;
               end else if (it.rx_byte == c.retry_code) begin
                  s.phase = PH_CREATE_START1;
               end
            end
            PH_OP_START: begin
               if (it.rx_byte == c.start_code) begin
                  s.phase = PH_OP_PW;
                  s.idx = 4'd0;
                  s.mism = 1'b0;
               end
            end
            PH_OP_PW: begin
               if (s.stored_pw[s.idx] != it.rx_byte) s.mism = 1'b1;
               s.idx = s.idx + 4'd1;
               if (s.idx >= PW_LEN) begin
                  s.idx = 4'd0;
                  o.res.tx_valid = 1'b1;
                  if (!s.mism) begin
                     o.res.tx_byte = TX_PASS;
                     s.attempts = 4'd0;
                     if (s.pend_open) begin
                        s.phase = PH_OPENING;
                        s.ticks = 6'd0;
                     end else begin
                        s.phase = PH_CREATE_START1;
                     end
                  end else begin
                     o.res.tx_byte = TX_FAIL;
                     if (s.attempts < ATTEMPT_MAX) s.attempts = s.attempts + 4'd1;
                     if (s.attempts >= c.attempt_limit) begin
                        s.phase = PH_ALARM;
                        s.ticks = 6'd0;
                     end else begin
                        s.phase = PH_IDLE;
                     end
                  end
                  s.pend_open = 1'b0;
               end
            end
            default: ;
         endcase
      end
      // forward run over or motion hold-off: look at the sensor now
      if (sample) begin
         o.res.tx_valid = 1'b1;
         if (it.motion) begin
            o.res.tx_byte = c.wait_code;
            s.phase = PH_MOTION;
         end else begin
            o.res.tx_byte = TX_FAIL;
            s.phase = PH_LOCKING;
            s.ticks = 6'd0;
         end
      end
      o.res.motor_drive = (s.phase == PH_OPENING) ? MOTOR_FORWARD :
                          (s.phase == PH_LOCKING) ? MOTOR_REVERSE : MOTOR_STOP;
      o.res.buzzer_active = (s.phase == PH_ALARM);
      o.res.busy_res = (s.phase == PH_OPENING) || (s.phase == PH_MOTION) ||
                       (s.phase == PH_LOCKING) || (s.phase == PH_ALARM);
      o.st = s;
      return o;
   endfunction

   // Queue an item and track the state it leads to; 1 when it is not ignored.
   function automatic bit queue_item(door_item_type it);
      door_step_type o;
      bit            useful;
      o = door_step(cfg, plan_state, it);
      useful = (o.st != plan_state) || o.res.tx_valid;
      plan_state = o.st;
      pending_items.push_back(it);
      return useful;
   endfunction

   function automatic door_item_type choose_item();
      door_item_type it;
      int            r;
      r = $urandom_range(99);
      it.command = CMD_BYTE;
      it.rx_byte = 8'($urandom_range(255));
      it.motion = ($urandom_range(99) < 45);
      case (plan_state.phase)
         PH_CREATE_START1, PH_CREATE_START2, PH_OP_START: begin
            if (plan_state.phase == PH_CREATE_START1) begin
               for (int i = 0; i < PW_LEN; i++) pw_plan[i] = 8'($urandom_range(255));
            end
            if (r < 80) it.rx_byte = cfg.start_code;
            else if (r < 90) it.command = CMD_TICK;
         end
         PH_CREATE_PW1: begin
            if (r < 95) it.rx_byte = pw_plan[plan_state.idx];
            else it.command = CMD_TICK;
         end
         PH_CREATE_PW2: begin
            if (r < 85) it.rx_byte = plan_state.first_pw[plan_state.idx];
         end
         PH_IDLE: begin
            if (r < 45) it.rx_byte = cfg.open_code;
            else if (r < 65) it.rx_byte = cfg.change_code;
            else if (r < 72) it.rx_byte = cfg.retry_code;
            else if (r >= 86) it.command = CMD_TICK;
         end
         PH_OP_PW: begin
            if (r < 90) it.rx_byte = plan_state.stored_pw[plan_state.idx];
         end
         PH_MOTION: begin
            if (r < 50) it.command = CMD_TICK;
         end
         default: begin
            // motor or alarm run: mostly ticks, a few bytes to be ignored
            if (r < 85) it.command = CMD_TICK;
         end
      endcase
      return it;
   endfunction

   task automatic random_items(int target);
      int done;
      done = 0;
      while (done < target) done += int'(queue_item(choose_item()));
   endtask

   task automatic byte_item(logic [7:0] b, logic m);
      void'(queue_item('{command: CMD_BYTE, rx_byte: b, motion: m}));
   endtask

   task automatic tick_item(logic m);
      void'(queue_item('{command: CMD_TICK, rx_byte: 8'($urandom_range(255)), motion: m}));
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_bus.valid || expected_replies.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= ($urandom & 32'hFFFF_FF00) | {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_OPEN_CODE:     cfg.open_code = val;
         REG_CHANGE_CODE:   cfg.change_code = val;
         REG_RETRY_CODE:    cfg.retry_code = val;
         REG_START_CODE:    cfg.start_code = val;
         REG_WAIT_CODE:     cfg.wait_code = val;
         REG_ATTEMPT_LIMIT: cfg.attempt_limit = val[3:0];
         REG_MOTOR_TICKS:   cfg.motor_ticks = val[5:0];
         REG_ALARM_TICKS:   cfg.alarm_ticks = val[5:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int k);
      lock_cfg_type nc;
      nc.open_code     = 8'($urandom_range(255));
      nc.change_code   = 8'($urandom_range(255));
      nc.retry_code    = 8'($urandom_range(255));
      nc.start_code    = 8'($urandom_range(255));
      nc.wait_code     = 8'($urandom_range(255));
      nc.attempt_limit = 4'($urandom_range(15, 1));
      nc.motor_ticks   = 6'($urandom_range(6, 1));
      nc.alarm_ticks   = 6'($urandom_range(6, 1));
      if (k == 3) begin
         nc = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd255, 4'd15, 6'd63, 6'd63};
      end else if (k == 6) begin
         // all three request codes equal, zero limits
         nc.change_code   = nc.open_code;
         nc.retry_code    = nc.open_code;
         nc.attempt_limit = 4'd0;
         nc.motor_ticks   = 6'd0;
         nc.alarm_ticks   = 6'd0;
      end
      csr_write(REG_OPEN_CODE, nc.open_code);
      csr_write(REG_CHANGE_CODE, nc.change_code);
      csr_write(REG_RETRY_CODE, nc.retry_code);
      csr_write(REG_START_CODE, nc.start_code);
      csr_write(REG_WAIT_CODE, nc.wait_code);
      csr_write(REG_ATTEMPT_LIMIT, {4'd0, nc.attempt_limit});
      csr_write(REG_MOTOR_TICKS, {2'd0, nc.motor_ticks});
      csr_write(REG_ALARM_TICKS, {2'd0, nc.alarm_ticks});
   endtask

   task automatic log_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   function automatic string fmt_result(door_result_type r);
      return $sformatf("tx_valid=%0d tx_byte=%0d motor=%0d buzzer=%0d busy=%0d",
                       r.tx_valid, r.tx_byte, r.motor_drive, r.buzzer_active, r.busy_res);
   endfunction

   // Driver: predict on acceptance, then present the next pending item.
   always @(posedge clock) begin : req_driver
      door_item_type it;
      door_step_type o;
      if (reset) begin
         ctl_state = lock_reset_state();
         drv_req_valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            it = '{command: req_bus.command, rx_byte: req_bus.rx_byte,
                   motion: req_bus.motion};
            o = door_step(cfg, ctl_state, it);
            ctl_state = o.st;
            expected_replies.push_back(o.res);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
               it = pending_items.pop_front();
               drv_req_valid <= 1'b1;
               drv_command   <= it.command;
               drv_rx_byte   <= it.rx_byte;
               drv_motion    <= it.motion;
            end else begin
               drv_req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      door_result_type got;
      door_result_type want;
      if (reset) begin
         drv_rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.tx_valid      = rsp_bus.tx_valid;
            got.tx_byte       = rsp_bus.tx_byte;
            got.motor_drive   = rsp_bus.motor_drive;
            got.buzzer_active = rsp_bus.buzzer_active;
            got.busy_res      = rsp_bus.busy_res;
            if (expected_replies.size() == 0) begin
               log_fail({"unexpected result: ", fmt_result(got)});
            end else begin
               want = expected_replies.pop_front();
               if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                   got.motor_drive !== want.motor_drive ||
                   got.buzzer_active !== want.buzzer_active ||
                   got.busy_res !== want.busy_res)
                  log_fail({"mismatch: expected ", fmt_result(want),
                            " actual ", fmt_result(got)});
            end
         end
         drv_rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : stimulus
      logic [PW_LEN-1:0][7:0] pw;
      cfg = '{OPEN_CODE_RST, CHANGE_CODE_RST, RETRY_CODE_RST, START_CODE_RST,
              WAIT_CODE_RST, ATTEMPT_LIMIT_RST, MOTOR_TICKS_RST, ALARM_TICKS_RST};
      plan_state = lock_reset_state();
      pw = {8'h5A, START_CODE_RST, OPEN_CODE_RST, 8'hFF, 8'h00};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Short motor run so the directed open sequence completes quickly
      csr_write(REG_MOTOR_TICKS, 8'd2);

      // Create a password holding extreme bytes and code values, then open
      byte_item(START_CODE_RST, 1'b1);
      for (int i = 0; i < PW_LEN; i++) byte_item(pw[i], i[0]);
      byte_item(START_CODE_RST, 1'b0);
      for (int i = 0; i < PW_LEN; i++) byte_item(pw[i], ~i[0]);
      byte_item(OPEN_CODE_RST, 1'b0);
      byte_item(START_CODE_RST, 1'b1);
      for (int i = 0; i < PW_LEN; i++) byte_item(pw[i], 1'b0);
      tick_item(1'b0);
      tick_item(1'b1);       // forward run ends while motion is seen
      byte_item(8'h77, 1'b1); // any item keeps sampling motion
      tick_item(1'b0);
      tick_item(1'b0);
      tick_item(1'b0);
      drain();

      for (int k = 0; k < 8; k++) begin
         set_config(k);
         case (k % 4)
            0: begin send_idle = 0;  stall_pct = 0;  end
            1: begin send_idle = 64; stall_pct = 0;  end
            2: begin send_idle = 0;  stall_pct = 64; end
            default: begin send_idle = 24; stall_pct = 24; end
         endcase
         random_items(120);
         // hold the sender until every reply is back
         if (k == 1) drain();
         random_items(120);
         drain();
      end

      if (fail_count == 0 && expected_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[password_door_lock_controller.f]
sv/pdl_pkg.sv
sv/pdl_if.sv
sv/password_door_lock_controller.sv
tb/password_door_lock_controller_tb.sv
